/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* hdl/ssstat_pkg.sv */
// ----------------------------------------------------------------------------
// ssstat_pkg
// types and constants of the sample set statistics unit
// ----------------------------------------------------------------------------
package ssstat_pkg;

  localparam int MAX_SAMPLES = 4096;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SMP_W  = 16;
  localparam int SUM_W  = 29;
  localparam int SQ_W   = 43;
  localparam int MAG_W  = 28;
  localparam int PROD_W = 55;
  localparam int DEN_W  = 26;
  localparam int DIVD_W = 63;
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 39;

  localparam logic [1:0] CMD_ADD        = 2'd0;
  localparam logic [1:0] CMD_ADD_FINISH = 2'd1;
  localparam logic [1:0] CMD_FINISH     = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_SINGLE   = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [SMP_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]         sample_count;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [VAR_W-1:0]         variance_q8;
    logic signed [SMP_W-1:0]  minimum;
    logic signed [SMP_W-1:0]  maximum;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         square_sum;
    logic signed [SMP_W-1:0] min;
    logic signed [SMP_W-1:0] max;
    logic                    overflow;
  } set_snap_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctl_t;

endpackage

/* hdl/ssstat_front.sv */
// ----------------------------------------------------------------------------
// ssstat_front
// accepts transactions, squares samples and keeps the running accumulators
// ----------------------------------------------------------------------------
module ssstat_front
  import ssstat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      push,
  output set_snap_t push_data,
  input  logic      full
);

  logic                    a_valid_r;
  in_item_t                a_item_r;
  logic [30:0]             a_sq_r;
  logic signed [31:0]      sq_full;

  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sqsum_r;
  logic signed [SMP_W-1:0] min_r;
  logic signed [SMP_W-1:0] max_r;
  logic                    ovf_r;

  set_snap_t               acc_nxt;
  logic                    b_finish;
  logic                    b_add;
  logic                    b_go;

  assign sq_full  = in_data.sample * in_data.sample;
  assign b_finish = (a_item_r.command == CMD_ADD_FINISH) || (a_item_r.command == CMD_FINISH);
  assign b_add    = (a_item_r.command == CMD_ADD) || (a_item_r.command == CMD_ADD_FINISH);
  assign b_go     = a_valid_r && (!b_finish || !full);
  assign in_ready = !a_valid_r || b_go;

  always_comb begin
    acc_nxt.count      = count_r;
    acc_nxt.sum        = sum_r;
    acc_nxt.square_sum = sqsum_r;
    acc_nxt.min        = min_r;
    acc_nxt.max        = max_r;
    acc_nxt.overflow   = ovf_r;
    if (b_add) begin
      if (count_r == CNT_W'(MAX_SAMPLES)) begin
        acc_nxt.overflow = 1'b1;
      end else begin
        if (count_r == '0) begin
          acc_nxt.min = a_item_r.sample;
          acc_nxt.max = a_item_r.sample;
        end else begin
          if (a_item_r.sample < min_r) acc_nxt.min = a_item_r.sample;
          if (a_item_r.sample > max_r) acc_nxt.max = a_item_r.sample;
        end
        acc_nxt.count      = count_r + CNT_W'(1);
        acc_nxt.sum        = sum_r + SUM_W'(a_item_r.sample);
        acc_nxt.square_sum = sqsum_r + SQ_W'(a_sq_r);
      end
    end
  end

  assign push      = b_go && b_finish;
  assign push_data = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      count_r   <= '0;
      sum_r     <= '0;
      sqsum_r   <= '0;
      min_r     <= '0;
      max_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_go) begin
        if (b_finish) begin
          count_r <= '0;
          sum_r   <= '0;
          sqsum_r <= '0;
          min_r   <= '0;
          max_r   <= '0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= acc_nxt.count;
          sum_r   <= acc_nxt.sum;
          sqsum_r <= acc_nxt.square_sum;
          min_r   <= acc_nxt.min;
          max_r   <= acc_nxt.max;
          ovf_r   <= acc_nxt.overflow;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item_r <= in_data;
      a_sq_r   <= sq_full[30:0];
    end
  end

endmodule

/* hdl/ssstat_queue.sv */
// ----------------------------------------------------------------------------
// ssstat_queue
// two-entry queue of finished set accumulators
// ----------------------------------------------------------------------------
module ssstat_queue
  import ssstat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  set_snap_t  push_data,
  input  logic       pop,
  output set_snap_t  pop_data,
  output queue_ctl_t ctl
);

  set_snap_t  mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push;
  logic       do_pop;

  assign ctl.full  = (fill_r == 2'd2);
  assign ctl.empty = (fill_r == 2'd0);
  assign do_push   = push && !ctl.full;
  assign do_pop    = pop && !ctl.empty;
  assign ctl.push  = do_push;
  assign ctl.pop   = do_pop;
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) fill_r <= fill_r + 2'd1;
      else if (do_pop && !do_push) fill_r <= fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

endmodule

/* hdl/ssstat_div.sv */
// ----------------------------------------------------------------------------
// ssstat_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssstat_div
  import ssstat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVD_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [DIVD_W-1:0]   quo_r;
  logic [DEN_W-1:0]    rem_r;
  logic [DEN_W-1:0]    div_r;
  logic [DEN_W:0]      trial;
  logic                fits;

  assign trial    = {rem_r, quo_r[DIVD_W-1]};
  assign fits     = trial >= {1'b0, div_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(DIVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], fits};
      rem_r <= fits ? DEN_W'(trial - {1'b0, div_r}) : trial[DEN_W-1:0];
    end
  end

endmodule

/* hdl/ssstat_back.sv */
// ----------------------------------------------------------------------------
// ssstat_back
// turns a finished set into count, mean, variance, extremes and status
// ----------------------------------------------------------------------------
module ssstat_back
  import ssstat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  queue_ctl_t q_ctl,
  input  set_snap_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MEAN = 3'd2;
  localparam logic [2:0] S_VAR  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  out_item_t           out_r;
  logic [CNT_W-1:0]    n_r;
  logic                neg_r;
  logic [MAG_W-1:0]    mag_r;
  logic [PROD_W-1:0]   mag_sq_r;
  logic [DEN_W-1:0]    den_r;
  logic [PROD_W-1:0]   mcand_r;
  logic [CNT_W-1:0]    mplier_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SUM_W-1:0]    sum_abs;
  logic [1:0]          status_nxt;

  logic                div_start;
  logic [DIVD_W-1:0]   div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic                div_done;
  logic [DIVD_W-1:0]   div_quotient;
  logic [MEAN_W-1:0]   mean_mag;

  ssstat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign sum_abs   = q_data.sum[SUM_W-1] ? SUM_W'(-q_data.sum) : SUM_W'(q_data.sum);
  assign q_pop     = (state_r == S_IDLE) && !q_ctl.empty;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;
  assign mean_mag  = div_quotient[MEAN_W-1:0];

  always_comb begin
    if (q_data.count == '0) status_nxt = STATUS_EMPTY;
    else if (q_data.overflow) status_nxt = STATUS_OVERFLOW;
    else if (q_data.count == CNT_W'(1)) status_nxt = STATUS_SINGLE;
    else status_nxt = STATUS_OK;
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIVD_W'({mag_r, 8'b0});
    div_divisor  = DEN_W'(n_r);
    state_nxt    = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_ctl.empty) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (n_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        if (div_done) begin
          if (n_r == CNT_W'(1)) begin
            state_nxt = S_OUT;
          end else begin
            div_start    = 1'b1;
            div_dividend = {prod_r - mag_sq_r, 8'b0};
            div_divisor  = den_r;
            state_nxt    = S_VAR;
          end
        end
      end
      S_VAR: begin
        if (div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r                <= q_data.count;
      neg_r              <= q_data.sum[SUM_W-1];
      mag_r              <= sum_abs[MAG_W-1:0];
      mcand_r            <= PROD_W'(q_data.square_sum);
      mplier_r           <= q_data.count;
      prod_r             <= '0;
      out_r.sample_count <= q_data.count;
      out_r.mean_q8      <= '0;
      out_r.variance_q8  <= '0;
      out_r.minimum      <= q_data.min;
      out_r.maximum      <= q_data.max;
      out_r.status       <= status_nxt;
    end else begin
      if (mplier_r != '0) begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[CNT_W-1:1]};
      end
      if (state_r == S_PREP) begin
        mag_sq_r <= PROD_W'(mag_r * mag_r);
        den_r    <= DEN_W'(n_r * (n_r - CNT_W'(1)));
      end
      if (state_r == S_MEAN && div_done) begin
        out_r.mean_q8 <= neg_r ? MEAN_W'(-mean_mag) : mean_mag;
      end
      if (state_r == S_VAR && div_done) begin
        out_r.variance_q8 <= (|div_quotient[DIVD_W-1:VAR_W]) ? {VAR_W{1'b1}}
                                                              : div_quotient[VAR_W-1:0];
      end
    end
  end

endmodule

/* hdl/sample_set_statistics_unit.sv */
// ----------------------------------------------------------------------------
// sample_set_statistics_unit
// count, mean, unbiased variance, minimum and maximum of sample sets
// ----------------------------------------------------------------------------
//  channel  direction  payload     handshake
//  in_      input      in_item_t   in_valid / in_ready
//  out_     output     out_item_t  out_valid / out_ready
//
//  the front takes one transaction per cycle; a finish stalls only while
//  the two-entry set queue is full
//  the back divides bit-serially, once for the mean and, for a set of two or
//  more samples, once more for the variance; a single sample skips the
//  variance division and an empty set skips both divisions
//  reset is synchronous and clears all control state; no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sample_set_statistics_unit
  import ssstat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       push;
  set_snap_t  push_data;
  set_snap_t  pop_data;
  logic       pop;
  queue_ctl_t q_ctl;

  ssstat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (q_ctl.full)
  );

  ssstat_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .ctl       (q_ctl)
  );

  ssstat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctl     (q_ctl),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_NEVER(a_no_lost_set, clk, rst_n, push && !q_ctl.push, "finished set dropped at full queue")
  `ASSERT_PROP(a_empty_zero, clk, rst_n, (out_valid && out_data.status == STATUS_EMPTY) |-> (out_data.sample_count == '0 && out_data.mean_q8 == '0), "empty set result not zero")
  `ASSERT_PROP(a_small_var, clk, rst_n, (out_valid && out_data.sample_count < 13'd2) |-> (out_data.variance_q8 == '0), "variance of fewer than two samples not zero")
  `ASSERT_PROP(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result changed while stalled")

endmodule
